FILE: hdl/mss_pkg.sv
// Shared types and constants for the step sequencer tick unit.
package mss_pkg;

  // Input item kinds carried on in_tuser.
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_STEP_WR = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_STEPS_IN_USE  = 2'd0,
    REG_STEP_LENGTH   = 2'd1,
    REG_MIDI_CHANNEL  = 2'd2,
    REG_SCENE_ENABLED = 2'd3
  } reg_idx_t;

  localparam logic [6:0] OFF_VELOCITY = 7'h40;
  localparam logic [7:0] LEN_MAX      = 8'd240;
  localparam logic signed [7:0] OFS_MIN = -8'sd120;
  localparam logic signed [7:0] OFS_MAX = 8'sd120;
  localparam logic [6:0] STEP_LEN_MAX = 7'd96;
  localparam logic [6:0] RST_NOTE     = 7'd64;
  localparam logic [6:0] RST_VEL      = 7'd64;
  localparam logic [7:0] RST_LEN      = 8'd24;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_CHECK, ST_SEARCH, ST_PICK, ST_OFF, ST_ON, ST_FINISH
  } state_t;

  // Step contents as written into a cell.
  typedef struct packed {
    logic [6:0]        note;
    logic [6:0]        vel;
    logic [7:0]        len;
    logic signed [7:0] ofs;
    logic              on;
  } step_t;

  // Control broadcast to all cells; load and norm act on every cell, wr, clr and set only on the selected one.
  typedef struct packed {
    logic load;   // load raw event times
    logic norm;   // one wrap-correction step on event times
    logic wr;     // write step contents, end sounding
    logic clr;    // end sounding
    logic set;    // mark sounding
  } cell_ctl_t;

  // One MIDI message.
  typedef struct packed {
    logic       is_on;
    logic [3:0] ch;
    logic [6:0] note;
    logic [6:0] vel;
  } msg_t;

endpackage

FILE: hdl/midi_step_sequencer_tick_unit.sv
// Top level of the step sequencer tick unit: control, position and message output.
//
//  channel | handshake            | payload
//  in      | in_tvalid/in_tready  | tuser operation; tdata step fields
//  out     | out_tvalid/out_tready| tuser is_note_on; tdata message; tlast end of run
//  cfg     | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// A write is accepted in idle and then passes a finish state that hands off its note-off.
// A tick is accepted in idle, then runs a fold phase (wrap corrections on the position
// and on every event time, adding or subtracting the loop span) and a check state.
// Each event played then passes through search down the cell chain, pick, note-off and
// note-on; a final empty search and pick plus a finish state close the tick.
// Output stalls hold the note-off, note-on and finish states. Reset is synchronous,
// active low, and restores the power-on step table.
module midi_step_sequencer_tick_unit import mss_pkg::*; #(
  parameter int MAX_STEPS = 16,
  parameter int MINORS_PER_STEP = 384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // operation
  input  logic [39:0] in_tdata,   // step_index, note_value, velocity_value,
                                  // length_value, offset_value, step_on
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // is_note_on
  output logic [23:0] out_tdata,  // channel_out, note_out, velocity_out
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int PW = $clog2(MAX_STEPS + 1);
  localparam int MW = $clog2(MINORS_PER_STEP);
  localparam int TW = $clog2(MAX_STEPS * MINORS_PER_STEP);
  localparam int VW = $clog2(MAX_STEPS * MINORS_PER_STEP + 2048) + 2;
  localparam int KW = TW + SW + 2;

  // Configuration registers.
  logic [4:0] steps_in_use_r;
  logic [6:0] step_length_r;
  logic [3:0] midi_channel_r;
  logic       scene_enabled_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_in_use_r  <= 5'd4;
      step_length_r   <= 7'd4;
      midi_channel_r  <= 4'd0;
      scene_enabled_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_STEPS_IN_USE:  steps_in_use_r  <= cfg_data[4:0];
        REG_STEP_LENGTH:   step_length_r   <= cfg_data;
        REG_MIDI_CHANNEL:  midi_channel_r  <= cfg_data[3:0];
        REG_SCENE_ENABLED: scene_enabled_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input unpacking with write saturation.
  step_t       wdata;
  logic [3:0]  in_idx;
  logic [7:0]  in_len;
  logic signed [7:0] in_ofs;

  always_comb begin
    in_idx = in_tdata[3:0];
    in_len = in_tdata[25:18];
    in_ofs = $signed(in_tdata[33:26]);
    wdata.note = in_tdata[10:4];
    wdata.vel  = in_tdata[17:11];
    wdata.len  = (in_len > LEN_MAX) ? LEN_MAX : in_len;
    wdata.ofs  = (in_ofs < OFS_MIN) ? OFS_MIN : ((in_ofs > OFS_MAX) ? OFS_MAX : in_ofs);
    wdata.on   = in_tdata[34];
  end

  // Loop size and advance, limited to their legal ranges.
  logic [PW-1:0] wrap;
  logic [TW:0]   span;
  logic [6:0]    adv;

  always_comb begin
    if (steps_in_use_r == 5'd0)                 wrap = PW'(1);
    else if (32'(steps_in_use_r) > MAX_STEPS)   wrap = PW'(MAX_STEPS);
    else                                        wrap = PW'(steps_in_use_r);
    span = (TW+1)'(32'(wrap) * MINORS_PER_STEP);
    adv  = (step_length_r > STEP_LEN_MAX) ? STEP_LEN_MAX : step_length_r;
  end

  // Control and datapath registers.
  state_t         state_r, state_nxt;
  logic [SW-1:0]  pos_step_r, pos_step_nxt;
  logic [MW-1:0]  pos_minor_r, pos_minor_nxt;
  logic [PW-1:0]  ptmp_r, ptmp_nxt;
  logic [TW-1:0]  now_r, now_nxt, last_r, last_nxt;
  logic [SW-1:0]  cnt_r, cnt_nxt;
  logic [SW-1:0]  sel_step_r, sel_step_nxt;
  logic           sel_on_r, sel_on_nxt;
  logic           prev_valid_r, prev_valid_nxt;
  logic [KW-1:0]  prev_key_r, prev_key_nxt;
  logic           hold_valid_r, hold_valid_nxt;
  msg_t           hold_r, hold_nxt;
  logic           out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  msg_t           out_r, out_nxt;

  // Cell array signals.
  cell_ctl_t              ctl;
  logic [MAX_STEPS-1:0]   sel_vec, active, done;
  logic [MAX_STEPS-1:0]   snd;
  logic [6:0]             note_a [MAX_STEPS];
  logic [6:0]             vel_a  [MAX_STEPS];
  logic [KW:0]            chain  [MAX_STEPS+1];

  logic in_acc, tick_acc, wr_acc, idx_ok, out_free, push_ok;
  logic snd_sel;
  logic [6:0] note_sel, vel_sel;
  logic [MW:0] total;
  logic        carry;
  logic [KW:0] tail;

  assign in_acc   = in_tvalid && in_tready;
  assign tick_acc = in_acc && (in_tuser == OP_TICK);
  assign wr_acc   = in_acc && (in_tuser == OP_STEP_WR);
  assign idx_ok   = 32'(in_idx) < MAX_STEPS;
  assign out_free = !out_valid_r || out_tready;
  assign push_ok  = !hold_valid_r || out_free;
  assign in_tready = (state_r == ST_IDLE);
  assign total    = (MW+1)'(pos_minor_r) + (MW+1)'(adv);
  assign carry    = total >= (MW+1)'(MINORS_PER_STEP);
  assign tail     = chain[MAX_STEPS];
  assign chain[0] = '0;

  // Step selection and read-back from the chosen cell.
  always_comb begin
    snd_sel  = 1'b0;
    note_sel = '0;
    vel_sel  = '0;
    for (int i = 0; i < MAX_STEPS; i++) begin
      active[i]  = 32'(wrap) > i;
      sel_vec[i] = (state_r == ST_IDLE) ? (32'(in_idx) == i) : (32'(sel_step_r) == i);
      if (sel_vec[i]) begin
        snd_sel  = snd[i];
        note_sel = note_a[i];
        vel_sel  = vel_a[i];
      end
    end
  end

  // Chain of step cells.
  for (genvar g = 0; g < MAX_STEPS; g++) begin : g_cell
    mss_cell #(
      .IDX(g), .MINORS_PER_STEP(MINORS_PER_STEP), .TW(TW), .SW(SW), .VW(VW)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .sel(sel_vec[g]), .wdata(wdata),
      .active(active[g]), .span(span), .now(now_r), .last(last_r),
      .prev_valid(prev_valid_r), .prev_key(prev_key_r),
      .carry_in(chain[g]), .carry_out(chain[g+1]), .done(done[g]),
      .sounding(snd[g]), .note(note_a[g]), .vel(vel_a[g])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (tick_acc) state_nxt = ST_NORM;
                 else if (wr_acc) state_nxt = ST_FINISH;
      ST_NORM:   if ((&done) && (ptmp_r < wrap)) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = (scene_enabled_r && (now_r != last_r)) ? ST_SEARCH : ST_FINISH;
      ST_SEARCH: if (cnt_r == SW'(MAX_STEPS - 1)) state_nxt = ST_PICK;
      ST_PICK:   state_nxt = tail[KW] ? ST_OFF : ST_FINISH;
      ST_OFF:    if (!snd_sel || push_ok) state_nxt = ST_ON;
      ST_ON:     if (!sel_on_r || push_ok) state_nxt = ST_SEARCH;
      ST_FINISH: if (!hold_valid_r || out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output control.
  always_comb begin
    pos_step_nxt   = pos_step_r;
    pos_minor_nxt  = pos_minor_r;
    ptmp_nxt       = ptmp_r;
    now_nxt        = now_r;
    last_nxt       = last_r;
    cnt_nxt        = cnt_r;
    sel_step_nxt   = sel_step_r;
    sel_on_nxt     = sel_on_r;
    prev_valid_nxt = prev_valid_r;
    prev_key_nxt   = prev_key_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_last_nxt   = out_last_r;
    out_nxt        = out_r;
    ctl            = '0;
    case (state_r)
      ST_IDLE: begin
        if (tick_acc) begin
          pos_minor_nxt = carry ? MW'(total - (MW+1)'(MINORS_PER_STEP)) : MW'(total);
          ptmp_nxt      = PW'(pos_step_r) + PW'(carry);
          ctl.load      = 1'b1;
        end else if (wr_acc && idx_ok) begin
          ctl.wr = 1'b1;
          if (snd_sel) begin
            hold_valid_nxt = 1'b1;
            hold_nxt = '{is_on: 1'b0, ch: midi_channel_r, note: note_sel, vel: OFF_VELOCITY};
          end
        end
      end
      ST_NORM: begin
        ctl.norm = 1'b1;
        if (ptmp_r >= wrap) ptmp_nxt = ptmp_r - wrap;
        pos_step_nxt = SW'(ptmp_r);
        now_nxt      = TW'(32'(ptmp_r) * MINORS_PER_STEP + 32'(pos_minor_r));
      end
      ST_CHECK: begin
        cnt_nxt        = '0;
        prev_valid_nxt = 1'b0;
        if (!(scene_enabled_r && (now_r != last_r))) last_nxt = now_r;
      end
      ST_SEARCH: cnt_nxt = cnt_r + SW'(1);
      ST_PICK: begin
        if (tail[KW]) begin
          sel_step_nxt   = tail[SW-1:0];
          sel_on_nxt     = tail[SW];
          prev_key_nxt   = tail[KW-1:0];
          prev_valid_nxt = 1'b1;
        end else begin
          last_nxt = now_r;
        end
      end
      ST_OFF: begin
        if (snd_sel && push_ok) begin
          ctl.clr = 1'b1;
          if (hold_valid_r) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b0;
            out_nxt       = hold_r;
          end
          hold_valid_nxt = 1'b1;
          hold_nxt = '{is_on: 1'b0, ch: midi_channel_r, note: note_sel, vel: OFF_VELOCITY};
        end
      end
      ST_ON: begin
        cnt_nxt = '0;
        if (sel_on_r && push_ok) begin
          ctl.set = 1'b1;
          if (hold_valid_r) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b0;
            out_nxt       = hold_r;
          end
          hold_valid_nxt = 1'b1;
          hold_nxt = '{is_on: 1'b1, ch: midi_channel_r, note: note_sel, vel: vel_sel};
        end
      end
      ST_FINISH: begin
        if (hold_valid_r && out_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          out_nxt        = hold_r;
          hold_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_step_r   <= '0;
      pos_minor_r  <= '0;
      last_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      prev_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      pos_step_r   <= pos_step_nxt;
      pos_minor_r  <= pos_minor_nxt;
      last_r       <= last_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_valid_r <= prev_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptmp_r     <= ptmp_nxt;
    now_r      <= now_nxt;
    sel_step_r <= sel_step_nxt;
    sel_on_r   <= sel_on_nxt;
    prev_key_r <= prev_key_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.is_on;
  assign out_tdata  = {6'd0, out_r.vel, out_r.note, out_r.ch};
  assign out_tlast  = out_last_r;

  // The held message is always flushed before a new request is taken.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_valid_r)
    else $error("held message left behind in idle");

  // At most one cell is addressed at a time.
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_vec))
    else $error("more than one step cell selected");

  // A tick request always starts the fold phase.
  a_tick_norm: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> (state_r == ST_NORM))
    else $error("tick request did not start event time fold");

endmodule

FILE: hdl/mss_cell.sv
// One step cell: step contents, sounding flag, event times and one stage of the min search.
module mss_cell import mss_pkg::*; #(
  parameter int IDX = 0,
  parameter int MINORS_PER_STEP = 384,
  parameter int TW = 13,
  parameter int SW = 4,
  parameter int VW = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              sel,
  input  step_t             wdata,
  input  logic              active,
  input  logic [TW:0]       span,
  input  logic [TW-1:0]     now,
  input  logic [TW-1:0]     last,
  input  logic              prev_valid,
  input  logic [TW+SW+1:0]  prev_key,
  input  logic [TW+SW+2:0]  carry_in,
  output logic [TW+SW+2:0]  carry_out,
  output logic              done,
  output logic              sounding,
  output logic [6:0]        note,
  output logic [6:0]        vel
);

  localparam int KW = TW + SW + 2;

  step_t                 step_r;
  logic                  snd_r;
  logic signed [VW-1:0]  von_r, voff_r;
  logic [KW:0]           carry_r;

  logic signed [VW-1:0]  span_s, raw_on, raw_off;
  logic                  on_ok, off_ok;
  logic [TW-1:0]         t_on, t_off;
  logic                  in_on, in_off, wr_on, wr_off;
  logic [KW-1:0]         key_on, key_off;
  logic                  c_on, c_off;
  logic [KW:0]           best;

  assign span_s  = VW'(span);
  assign raw_on  = VW'(IDX * MINORS_PER_STEP) + (VW'(step_r.ofs) <<< 2);
  assign raw_off = raw_on + VW'({step_r.len, 2'b00});
  assign on_ok   = (von_r >= 0) && (von_r < span_s);
  assign off_ok  = (voff_r >= 0) && (voff_r < span_s);
  assign done    = !active || !step_r.on || (on_ok && off_ok);

  // Step contents and sounding flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '{note: RST_NOTE, vel: RST_VEL, len: RST_LEN, ofs: 8'sd0, on: 1'b1};
      snd_r  <= 1'b0;
    end else if (sel && ctl.wr) begin
      step_r <= wdata;
      snd_r  <= 1'b0;
    end else if (sel && ctl.clr) begin
      snd_r <= 1'b0;
    end else if (sel && ctl.set) begin
      snd_r <= 1'b1;
    end
  end

  // Event times: load raw, then fold into the loop one span per cycle.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      von_r  <= raw_on;
      voff_r <= raw_off;
    end else if (ctl.norm) begin
      if (von_r < 0) von_r <= von_r + span_s;
      else if (von_r >= span_s) von_r <= von_r - span_s;
      if (voff_r < 0) voff_r <= voff_r + span_s;
      else if (voff_r >= span_s) voff_r <= voff_r - span_s;
    end
  end

  // Window test and sort keys for this step's off and on events.
  always_comb begin
    t_on  = von_r[TW-1:0];
    t_off = voff_r[TW-1:0];
    if (now > last) begin
      in_on  = (t_on > last) && (t_on <= now);
      in_off = (t_off > last) && (t_off <= now);
      wr_on  = 1'b0;
      wr_off = 1'b0;
    end else begin
      in_on  = (t_on > last) || (t_on <= now);
      in_off = (t_off > last) || (t_off <= now);
      wr_on  = t_on <= now;
      wr_off = t_off <= now;
    end
    key_on  = {wr_on,  t_on,  1'b1, SW'(IDX)};
    key_off = {wr_off, t_off, 1'b0, SW'(IDX)};
    c_on  = active && step_r.on && in_on  && (!prev_valid || key_on  > prev_key);
    c_off = active && step_r.on && in_off && (!prev_valid || key_off > prev_key);
  end

  // Keep the smallest candidate seen so far along the chain.
  always_comb begin
    best = carry_in;
    if (c_off && (!best[KW] || key_off < best[KW-1:0])) best = {1'b1, key_off};
    if (c_on  && (!best[KW] || key_on  < best[KW-1:0])) best = {1'b1, key_on};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) carry_r <= '0;
    else        carry_r <= best;
  end

  assign carry_out = carry_r;
  assign sounding  = snd_r;
  assign note      = step_r.note;
  assign vel       = step_r.vel;

endmodule

FILE: tb/tb_midi_step_sequencer_tick_unit.sv
// Self-checking testbench for the step sequencer tick unit, with scoreboard and stimulus.
module tb_midi_step_sequencer_tick_unit import mss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTEPS = 16;
  localparam int MINORS = 384;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 300;

  // One expected or observed MIDI message.
  typedef struct packed {
    bit       on;
    bit [3:0] ch;
    bit [6:0] note;
    bit [6:0] vel;
    bit       last;
  } midi_msg_t;

  // One input request as seen by the block.
  typedef struct {
    bit              op;
    bit [3:0]        idx;
    bit [6:0]        note;
    bit [6:0]        vel;
    bit [7:0]        len;
    bit signed [7:0] ofs;
    bit              on;
  } seq_req_t;

  // Scoreboard: keeps its own copy of the sequencer and the messages still due.
  class note_scoreboard;
    bit [4:0] steps_reg;
    bit [6:0] adv_reg;
    bit [3:0] chan_reg;
    bit       enable_reg;
    int       pos_s, pos_m, last_s, last_m;
    step_t    steps[NSTEPS];
    bit       sounding[NSTEPS];
    midi_msg_t due[$];
    int       n_bad;
    int       n_seen;

    function new();
      steps_reg = 4;
      adv_reg = 4;
      chan_reg = 0;
      enable_reg = 1;
      pos_s = 0; pos_m = 0; last_s = 0; last_m = 0;
      n_bad = 0;
      n_seen = 0;
      for (int s = 0; s < NSTEPS; s++) begin
        steps[s] = '{note: RST_NOTE, vel: RST_VEL, len: RST_LEN, ofs: 8'sd0, on: 1'b1};
        sounding[s] = 0;
      end
    endfunction

    function void set_reg(reg_idx_t idx, bit [6:0] val);
      case (idx)
        REG_STEPS_IN_USE:  steps_reg = val[4:0];
        REG_STEP_LENGTH:   adv_reg = val;
        REG_MIDI_CHANNEL:  chan_reg = val[3:0];
        REG_SCENE_ENABLED: enable_reg = val[0];
        default: ;
      endcase
    endfunction

    function void push_msg(bit on, bit [6:0] note, bit [6:0] vel);
      due.push_back('{on: on, ch: chan_reg, note: note, vel: vel, last: 1'b0});
    endfunction

    // Ends a sounding note of the step, then starts it again for an on event.
    function void play_event(int s, bit is_on);
      if (sounding[s]) begin
        push_msg(1'b0, steps[s].note, OFF_VELOCITY);
        sounding[s] = 0;
      end
      if (is_on) begin
        push_msg(1'b1, steps[s].note, steps[s].vel);
        sounding[s] = 1;
      end
    endfunction

    // Advance the position and play every event that falls in the passed interval.
    function void advance_position();
      int wrap, adv, total, last_t, now_t, loop_len, on_t, off_t, t;
      bit inside_win, wrapped;
      longint unsigned keys[$];
      wrap = (steps_reg == 0) ? 1 : ((steps_reg > NSTEPS) ? NSTEPS : int'(steps_reg));
      adv = (adv_reg > STEP_LEN_MAX) ? int'(STEP_LEN_MAX) : int'(adv_reg);
      total = pos_m + adv;
      pos_s = (pos_s + total / MINORS) % wrap;
      pos_m = total % MINORS;
      last_t = last_s * MINORS + last_m;
      now_t = pos_s * MINORS + pos_m;
      loop_len = wrap * MINORS;
      if (enable_reg && now_t != last_t) begin
        for (int s = 0; s < wrap; s++) begin
          if (!steps[s].on) continue;
          on_t = s * MINORS + int'(steps[s].ofs) * 4;
          on_t = ((on_t % loop_len) + loop_len) % loop_len;
          off_t = (on_t + int'(steps[s].len) * 4) % loop_len;
          for (int k = 0; k < 2; k++) begin
            t = k ? on_t : off_t;
            if (now_t > last_t) begin
              inside_win = t > last_t && t <= now_t;
              wrapped = 0;
            end else begin
              inside_win = t > last_t || t <= now_t;
              wrapped = t <= now_t;
            end
            if (inside_win)
              keys.push_back((longint'(wrapped) << 40) | (longint'(t) << 16) |
                             (longint'(k) << 8) | longint'(s));
          end
        end
        keys.sort();
        foreach (keys[i]) play_event(int'(keys[i][7:0]), keys[i][8]);
      end
      last_s = pos_s;
      last_m = pos_m;
    endfunction

    // Note an accepted request and queue the messages it causes.
    function void note_request(seq_req_t r);
      int n_prior;
      int ofs_i;
      n_prior = due.size();
      if (r.op == OP_TICK) begin
        advance_position();
      end else begin
        if (sounding[r.idx]) begin
          push_msg(1'b0, steps[r.idx].note, OFF_VELOCITY);
          sounding[r.idx] = 0;
        end
        ofs_i = int'(r.ofs);
        if (ofs_i < int'(OFS_MIN)) ofs_i = int'(OFS_MIN);
        if (ofs_i > int'(OFS_MAX)) ofs_i = int'(OFS_MAX);
        steps[r.idx] = '{note: r.note, vel: r.vel,
                         len: (r.len > LEN_MAX) ? LEN_MAX : r.len,
                         ofs: ofs_i[7:0], on: r.on};
      end
      if (due.size() > n_prior) due[due.size() - 1].last = 1;
    endfunction

    // Compare one accepted message with the oldest one due.
    function void check_msg(midi_msg_t got);
      midi_msg_t want;
      n_seen++;
      if (due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected message: on=%0d ch=%0d note=%0d vel=%0d last=%0d",
                   got.on, got.ch, got.note, got.vel, got.last);
        return;
      end
      want = due.pop_front();
      if (want != got) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("message mismatch: expected on=%0d ch=%0d note=%0d vel=%0d last=%0d,",
                   want.on, want.ch, want.note, want.vel, want.last);
          $display("  got on=%0d ch=%0d note=%0d vel=%0d last=%0d",
                   got.on, got.ch, got.note, got.vel, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic        in_tuser = 0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic        out_tuser;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  note_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_req = 0;
  bit  send_burst = 0;
  int  n_ticks = 0;
  int  n_writes = 0;

  midi_step_sequencer_tick_unit #(.MAX_STEPS(NSTEPS), .MINORS_PER_STEP(MINORS)) DUT (.*);

  // Clock.
  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_midi_step_sequencer_tick_unit: errors");
      $finish;
    end
  end

  // Message receiver: random stalls, calm stretches and one long hold-off.
  initial begin
    int stall;
    bit calm;
    midi_msg_t got;
    calm = 0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      stall = calm ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 0;
      end
      if (stall > 0) begin
        out_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      got = '{on: out_tuser, ch: out_tdata[3:0], note: out_tdata[10:4],
              vel: out_tdata[17:11], last: out_tlast};
      sb.check_msg(got);
    end
  end

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_req(seq_req_t r);
    int gap;
    if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= r.op;
    in_tdata <= {5'b0, r.on, r.ofs, r.len, r.vel, r.note, r.idx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    if (r.op == OP_TICK) n_ticks++;
    else n_writes++;
  endtask

  task automatic send_tick();
    seq_req_t r;
    r = '{op: OP_TICK, default: '0};
    r.idx = 4'($urandom);
    r.note = 7'($urandom);
    r.len = 8'($urandom);
    r.ofs = 8'($urandom);
    r.on = 1'($urandom);
    send_req(r);
  endtask

  task automatic send_write(int idx, int note, int vel, int len, int ofs, bit on);
    seq_req_t r;
    r = '{op: OP_STEP_WR, idx: 4'(idx), note: 7'(note), vel: 7'(vel), len: 8'(len),
          ofs: 8'(ofs), on: on};
    send_req(r);
  endtask

  // Wait until all messages are in and the block has settled, then write all registers.
  task automatic set_regs(int steps, int adv, int chan, int en);
    int vals[4];
    vals = '{steps, adv, chan, en};
    in_tvalid <= 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1;
      cfg_index <= 2'(i);
      cfg_data <= 7'(vals[i]);
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(reg_idx_t'(i), 7'(vals[i]));
    end
    cfg_valid <= 0;
  endtask

  // Random traffic: mostly ticks, with writes of random content.
  task automatic random_phase(int count, int steps);
    int len;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
        send_write($urandom_range(0, 5) == 0 ? $urandom_range(0, 15)
                                             : $urandom_range(0, steps > 0 ? steps - 1 : 0),
                   $urandom_range(0, 127), $urandom_range(0, 127), len,
                   $urandom_range(0, 255), $urandom_range(0, 4) != 0);
      end else begin
        send_tick();
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part: field extremes, saturation, muted steps, rewrite of a sounding step.
    set_regs(4, 96, 0, 1);
    repeat (4) send_tick();
    send_write(0, 127, 127, 255, -128, 1);
    send_write(15, 0, 0, 241, 127, 1);
    send_write(1, 0, 127, 0, -120, 1);
    send_write(2, 127, 0, 240, 120, 0);
    send_write(3, 64, 1, 2, 0, 1);
    repeat (12) send_tick();
    send_write(1, 10, 20, 5, 1, 1);
    send_write(3, 11, 21, 6, -1, 1);
    repeat (4) send_tick();

    // Random phases over several register settings.
    set_regs(16, 96, 5, 1);
    hold_req = 1;
    random_phase(45, 16);
    set_regs(1, 96, 15, 1);
    random_phase(40, 1);
    set_regs(0, 127, 3, 1);
    random_phase(35, 1);
    set_regs(31, 50, 9, 1);
    random_phase(40, 16);
    set_regs(8, 0, 2, 1);
    random_phase(15, 8);
    set_regs(2, 96, 1, 0);
    random_phase(25, 2);
    set_regs(6, 96, 7, 1);
    random_phase(45, 6);
    set_regs(3, 1, 12, 1);
    random_phase(40, 3);

    in_tvalid <= 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d ticks and %0d step writes over nine register settings.",
             n_ticks, n_writes);
    $display("Checked %0d note messages, %0d mismatches.", sb.n_seen, sb.n_bad);
    if (sb.n_bad == 0 && sb.due.size() == 0) begin
      $display("tb_midi_step_sequencer_tick_unit: clean");
    end else begin
      $display("tb_midi_step_sequencer_tick_unit: errors");
    end
    $finish;
  end

endmodule
